>>> src/scp_pkg.sv
// Shared constants, payload types and the divider step for the segment crossing unit.
// No dependencies; every other file imports this package.
package scp_pkg;

	localparam int COORD_BITS = 16;
	localparam int FRAC_BITS  = 16;

	localparam int PT_W  = 32;
	localparam int AB_W  = 18;
	localparam int C_W   = 34;
	localparam int OUT_W = 32;

	localparam int PROD_AB_W = 2 * AB_W;
	localparam int PROD_C_W  = AB_W + C_W;
	localparam int DET_W     = 2 * AB_W + 1;
	localparam int NUM_W     = AB_W + C_W + 1;
	localparam int DVD_W     = NUM_W + FRAC_BITS;
	localparam int Q_W       = OUT_W;
	localparam int HI_W      = DVD_W - Q_W;
	localparam int CMP_W     = (HI_W > DET_W) ? HI_W : DET_W;
	localparam int REM_W     = DET_W + 1;

	localparam int STEPS_PER_STAGE = 4;
	localparam int DIV_STAGES      = Q_W / STEPS_PER_STAGE;

	localparam int BOX_W = ((OUT_W > COORD_BITS + FRAC_BITS) ? OUT_W :
		COORD_BITS + FRAC_BITS) + 1;

	typedef struct packed {
		logic [PT_W-1:0] s1a;
		logic [PT_W-1:0] s1b;
		logic [PT_W-1:0] s2a;
		logic [PT_W-1:0] s2b;
	} seg_t;

	typedef struct packed {
		logic             neg;
		logic             ovf;
		logic [REM_W-1:0] rem;
		logic [Q_W-1:0]   quo;
		logic [Q_W-1:0]   low;
	} lane_t;

	typedef struct packed {
		logic [DET_W-1:0] den;
		lane_t            x;
		lane_t            y;
		seg_t             seg;
	} div_t;

	typedef struct packed {
		logic             bad;
		logic [OUT_W-1:0] val;
	} coord_t;

	// One restoring division step: bring in the next dividend bit, subtract if it fits.
	function automatic lane_t div_step(lane_t l, logic [DET_W-1:0] d);
		logic [REM_W-1:0] r;
		logic             qb;
		lane_t            o;
		o  = l;
		r  = {l.rem[REM_W-2:0], l.low[Q_W-1]};
		qb = (r >= {1'b0, d});
		if (qb) begin
			r = r - {1'b0, d};
		end
		o.rem = r;
		o.low = {l.low[Q_W-2:0], 1'b0};
		o.quo = {l.quo[Q_W-2:0], qb};
		return o;
	endfunction

endpackage

>>> src/scp_if.sv
// Valid/ready channels for segment pair beats and crossing result beats.
// Depends on scp_pkg for field widths.
interface scp_in_if import scp_pkg::*; ();
	logic                   valid;
	logic                   ready;
	logic [PT_W-1:0]        seg1_start;
	logic [PT_W-1:0]        seg1_end;
	logic [PT_W-1:0]        seg2_start;
	logic [PT_W-1:0]        seg2_end;
	logic signed [AB_W-1:0] line1_a;
	logic signed [AB_W-1:0] line1_b;
	logic signed [C_W-1:0]  line1_c;
	logic signed [AB_W-1:0] line2_a;
	logic signed [AB_W-1:0] line2_b;
	logic signed [C_W-1:0]  line2_c;

	modport source (output valid, seg1_start, seg1_end, seg2_start, seg2_end,
		line1_a, line1_b, line1_c, line2_a, line2_b, line2_c, input ready);
	modport sink (input valid, seg1_start, seg1_end, seg2_start, seg2_end,
		line1_a, line1_b, line1_c, line2_a, line2_b, line2_c, output ready);
endinterface

interface scp_out_if import scp_pkg::*; ();
	logic                    valid;
	logic                    ready;
	logic                    crosses;
	logic signed [OUT_W-1:0] cross_x;
	logic signed [OUT_W-1:0] cross_y;

	modport source (output valid, crosses, cross_x, cross_y, input ready);
	modport sink (input valid, crosses, cross_x, cross_y, output ready);
endinterface

>>> src/segment_crossing_point_unit.sv
// Top level of the segment crossing unit: front end, divider, box test.
// Depends on scp_pkg, scp_if, scp_front, scp_div and scp_box.
//
// Solves a1*x+b1*y+c1=0 and a2*x+b2*y+c2=0 by Cramer's rule and reports the
// crossing in signed Q16.16 when it lies inside both segment bounding boxes
// (bounds inclusive); parallel lines and out-of-range quotients give no
// crossing and zero coordinates. One beat is taken every cycle while no
// result beat waits on ready. The 32-bit restoring divider resolves 4
// quotient bits per stage for both coordinates at once. The whole pipeline
// holds while a result beat waits on ready, so nothing is dropped or
// repeated.
module segment_crossing_point_unit import scp_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	scp_in_if.sink  item,
	scp_out_if.source result
);

	logic en;
	logic front_vld, div_vld, out_vld;
	div_t front_dat, div_dat;
	seg_t seg;

	// Advance everything unless the output register holds an untaken beat.
	assign en         = !out_vld || result.ready;
	assign item.ready = en;
	assign result.valid = out_vld;

	assign seg = '{s1a: item.seg1_start, s1b: item.seg1_end,
		s2a: item.seg2_start, s2b: item.seg2_end};

	scp_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.vld     (item.valid),
		.seg     (seg),
		.a1      (item.line1_a),
		.b1      (item.line1_b),
		.c1      (item.line1_c),
		.a2      (item.line2_a),
		.b2      (item.line2_b),
		.c2      (item.line2_c),
		.vld_out (front_vld),
		.dat_out (front_dat)
	);

	scp_div u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.vld     (front_vld),
		.dat     (front_dat),
		.vld_out (div_vld),
		.dat_out (div_dat)
	);

	scp_box u_box (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.vld     (div_vld),
		.dat     (div_dat),
		.vld_out (out_vld),
		.crosses (result.crosses),
		.cross_x (result.cross_x),
		.cross_y (result.cross_y)
	);

endmodule

>>> src/scp_front.sv
// Front end: coefficient products, determinant and numerators, magnitudes,
// overflow check and divider seed. Four stages. Depends on scp_pkg.
module scp_front import scp_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   en,
	input  logic                   vld,
	input  seg_t                   seg,
	input  logic signed [AB_W-1:0] a1,
	input  logic signed [AB_W-1:0] b1,
	input  logic signed [C_W-1:0]  c1,
	input  logic signed [AB_W-1:0] a2,
	input  logic signed [AB_W-1:0] b2,
	input  logic signed [C_W-1:0]  c2,
	output logic                   vld_out,
	output div_t                   dat_out
);

	logic                        vld_s1, vld_s2, vld_s3, vld_s4;
	seg_t                        seg_s1, seg_s2, seg_s3;
	logic signed [PROD_AB_W-1:0] a1b2_s1, a2b1_s1;
	logic signed [PROD_C_W-1:0]  b1c2_s1, b2c1_s1, a2c1_s1, a1c2_s1;
	logic signed [DET_W-1:0]     det_s2;
	logic signed [NUM_W-1:0]     nx_s2, ny_s2;
	logic [DET_W-1:0]            dmag_s3;
	logic [NUM_W-1:0]            nxmag_s3, nymag_s3;
	logic                        negx_s3, negy_s3;
	div_t                        dat_s4;
	logic [DVD_W-1:0]            dvdx, dvdy;
	logic [HI_W-1:0]             hix, hiy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
		end else if (en) begin
			vld_s1 <= vld;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			seg_s1  <= seg;
			a1b2_s1 <= a1 * b2;
			a2b1_s1 <= a2 * b1;
			b1c2_s1 <= b1 * c2;
			b2c1_s1 <= b2 * c1;
			a2c1_s1 <= a2 * c1;
			a1c2_s1 <= a1 * c2;

			seg_s2 <= seg_s1;
			det_s2 <= DET_W'(a1b2_s1) - DET_W'(a2b1_s1);
			nx_s2  <= NUM_W'(b1c2_s1) - NUM_W'(b2c1_s1);
			ny_s2  <= NUM_W'(a2c1_s1) - NUM_W'(a1c2_s1);

			seg_s3   <= seg_s2;
			dmag_s3  <= det_s2[DET_W-1] ? DET_W'(-det_s2) : DET_W'(det_s2);
			nxmag_s3 <= nx_s2[NUM_W-1] ? NUM_W'(-nx_s2) : NUM_W'(nx_s2);
			nymag_s3 <= ny_s2[NUM_W-1] ? NUM_W'(-ny_s2) : NUM_W'(ny_s2);
			negx_s3  <= nx_s2[NUM_W-1] ^ det_s2[DET_W-1];
			negy_s3  <= ny_s2[NUM_W-1] ^ det_s2[DET_W-1];

			dat_s4 <= '{
				den: dmag_s3,
				x:   '{neg: negx_s3, ovf: (CMP_W'(hix) >= CMP_W'(dmag_s3)),
					rem: REM_W'(hix), quo: '0, low: dvdx[Q_W-1:0]},
				y:   '{neg: negy_s3, ovf: (CMP_W'(hiy) >= CMP_W'(dmag_s3)),
					rem: REM_W'(hiy), quo: '0, low: dvdy[Q_W-1:0]},
				seg: seg_s3
			};
		end
	end

	// Quotient needs more than Q_W bits (or det is zero) when the top part reaches det.
	always_comb begin
		dvdx = {nxmag_s3, {FRAC_BITS{1'b0}}};
		dvdy = {nymag_s3, {FRAC_BITS{1'b0}}};
		hix  = dvdx[DVD_W-1:Q_W];
		hiy  = dvdy[DVD_W-1:Q_W];
	end

	assign vld_out = vld_s4;
	assign dat_out = dat_s4;

endmodule

>>> src/scp_div.sv
// Pipelined restoring divider: both quotients in lockstep, STEPS_PER_STAGE
// bits per stage, DIV_STAGES stages. Depends on scp_pkg.
module scp_div import scp_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic en,
	input  logic vld,
	input  div_t dat,
	output logic vld_out,
	output div_t dat_out
);

	logic vld_q [DIV_STAGES+1];
	div_t dat_q [DIV_STAGES+1];

	assign vld_q[0] = vld;
	assign dat_q[0] = dat;

	for (genvar g = 0; g < DIV_STAGES; g++) begin : g_stage
		div_t nxt;

		always_comb begin
			nxt = dat_q[g];
			for (int k = 0; k < STEPS_PER_STAGE; k++) begin
				nxt.x = div_step(nxt.x, nxt.den);
				nxt.y = div_step(nxt.y, nxt.den);
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_q[g+1] <= 1'b0;
			end else if (en) begin
				vld_q[g+1] <= vld_q[g];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				dat_q[g+1] <= nxt;
			end
		end
	end

	assign vld_out = vld_q[DIV_STAGES];
	assign dat_out = dat_q[DIV_STAGES];

endmodule

>>> src/scp_box.sv
// Back end: sign and range of the quotients, then the inclusive box test
// against both segments into the result register. Depends on scp_pkg.
module scp_box import scp_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    en,
	input  logic                    vld,
	input  div_t                    dat,
	output logic                    vld_out,
	output logic                    crosses,
	output logic signed [OUT_W-1:0] cross_x,
	output logic signed [OUT_W-1:0] cross_y
);

	localparam logic [Q_W-1:0] POS_MAX = {1'b0, {(Q_W-1){1'b1}}};
	localparam logic [Q_W-1:0] NEG_MAX = {1'b1, {(Q_W-1){1'b0}}};

	logic                    vld_s1, vld_s2;
	coord_t                  x_s1, y_s1;
	seg_t                    seg_s1;
	logic                    hit_s2;
	logic [OUT_W-1:0]        x_s2, y_s2;
	logic                    hit;

	function automatic coord_t finish(lane_t l);
		coord_t c;
		c.bad = l.ovf | (l.neg ? (l.quo > NEG_MAX) : (l.quo > POS_MAX));
		c.val = l.neg ? OUT_W'(-l.quo) : OUT_W'(l.quo);
		return c;
	endfunction

	function automatic logic signed [BOX_W-1:0] scale(logic [COORD_BITS-1:0] c);
		return BOX_W'($signed({c, {FRAC_BITS{1'b0}}}));
	endfunction

	function automatic logic in_rng(logic signed [BOX_W-1:0] v,
		logic signed [BOX_W-1:0] e0, logic signed [BOX_W-1:0] e1);
		return ((v >= e0) && (v <= e1)) || ((v >= e1) && (v <= e0));
	endfunction

	function automatic logic in_box(logic signed [BOX_W-1:0] px,
		logic signed [BOX_W-1:0] py, logic [PT_W-1:0] p0, logic [PT_W-1:0] p1);
		return in_rng(px, scale(p0[2*COORD_BITS-1:COORD_BITS]),
				scale(p1[2*COORD_BITS-1:COORD_BITS]))
			&& in_rng(py, scale(p0[COORD_BITS-1:0]), scale(p1[COORD_BITS-1:0]));
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else if (en) begin
			vld_s1 <= vld;
			vld_s2 <= vld_s1;
		end
	end

	always_comb begin
		hit = !x_s1.bad && !y_s1.bad
			&& in_box(BOX_W'($signed(x_s1.val)), BOX_W'($signed(y_s1.val)),
				seg_s1.s1a, seg_s1.s1b)
			&& in_box(BOX_W'($signed(x_s1.val)), BOX_W'($signed(y_s1.val)),
				seg_s1.s2a, seg_s1.s2b);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			x_s1   <= finish(dat.x);
			y_s1   <= finish(dat.y);
			seg_s1 <= dat.seg;
			hit_s2 <= hit;
			x_s2   <= hit ? x_s1.val : '0;
			y_s2   <= hit ? y_s1.val : '0;
		end
	end

	assign vld_out = vld_s2;
	assign crosses = hit_s2;
	assign cross_x = x_s2;
	assign cross_y = y_s2;

endmodule

>>> verif/scp_tb_if.sv
// Testbench-side payload types for segment pair beats and crossing result beats.
// Depends on scp_pkg for field widths; holds no logic of its own.
package scp_tb_pkg;
	import scp_pkg::*;

	// Payload of one segment-pair beat as the testbench keeps it.
	typedef struct {
		logic [PT_W-1:0]        s1a, s1b, s2a, s2b;
		logic signed [AB_W-1:0] a1, b1, a2, b2;
		logic signed [C_W-1:0]  c1, c2;
	} pair_t;

	// One crossing result.
	typedef struct {
		logic                    hit;
		logic signed [OUT_W-1:0] x;
		logic signed [OUT_W-1:0] y;
	} cross_t;
endpackage

>>> verif/tb_segment_crossing_point_unit.sv
// Testbench for segment_crossing_point_unit: directed table, then random segment pairs.
// Depends on scp_pkg, scp_if, scp_tb_pkg and the RTL; checks every beat against a table entry or a predictor.
module tb_segment_crossing_point_unit;
	import scp_pkg::*;
	import scp_tb_pkg::*;

	localparam int N_RANDOM = 1200;
	localparam int LATENCY  = 14;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	int   n_err = 0;
	bit   feed_done = 1'b0;
	bit   timed_out = 1'b0;

	scp_in_if  item();
	scp_out_if result();

	segment_crossing_point_unit i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item.sink),
		.result (result.source)
	);

	always #5 clk = ~clk;

	cross_t crossings_due[$];

	task automatic report(input string what);
		$display("mismatch: %s", what);
		n_err++;
	endtask

	// Truncated fixed-point quotient; ok is cleared on zero divisor or overflow.
	function automatic logic signed [63:0] fx_quot(input logic signed [63:0] num,
		input logic signed [63:0] den, output bit ok);
		logic [63:0] n, d, q, r;
		bit neg;
		neg = (num < 0) != (den < 0);
		n = (num < 0) ? -num : num;
		d = (den < 0) ? -den : den;
		ok = 1'b0;
		if (d == 0) return 0;
		q = n / d;
		r = n % d;
		if (q > (64'd1 << (31 - FRAC_BITS))) return 0;
		for (int i = 0; i < FRAC_BITS; i++) begin
			r = r << 1;
			q = q << 1;
			if (r >= d) begin
				r = r - d;
				q[0] = 1'b1;
			end
		end
		if (neg ? (q > 64'h8000_0000) : (q > 64'h7FFF_FFFF)) return 0;
		ok = 1'b1;
		return neg ? -$signed(q) : $signed(q);
	endfunction

	function automatic bit within_box(input logic signed [63:0] px, py,
		input logic [PT_W-1:0] p0, p1);
		logic signed [63:0] x0, y0, x1, y1;
		x0 = 64'($signed(p0[2*COORD_BITS-1:COORD_BITS])) <<< FRAC_BITS;
		y0 = 64'($signed(p0[COORD_BITS-1:0])) <<< FRAC_BITS;
		x1 = 64'($signed(p1[2*COORD_BITS-1:COORD_BITS])) <<< FRAC_BITS;
		y1 = 64'($signed(p1[COORD_BITS-1:0])) <<< FRAC_BITS;
		return px >= ((x0 < x1) ? x0 : x1) && px <= ((x0 < x1) ? x1 : x0) &&
			py >= ((y0 < y1) ? y0 : y1) && py <= ((y0 < y1) ? y1 : y0);
	endfunction

	function automatic cross_t predict_crossing(input pair_t p);
		logic signed [63:0] det, nx, ny, x, y;
		bit okx, oky;
		cross_t c;
		det = 64'(p.a1) * 64'(p.b2) - 64'(p.a2) * 64'(p.b1);
		nx  = 64'(p.b1) * 64'(p.c2) - 64'(p.b2) * 64'(p.c1);
		ny  = 64'(p.a2) * 64'(p.c1) - 64'(p.a1) * 64'(p.c2);
		x = fx_quot(nx, det, okx);
		y = fx_quot(ny, det, oky);
		c.hit = okx && oky && within_box(x, y, p.s1a, p.s1b) && within_box(x, y, p.s2a, p.s2b);
		c.x = c.hit ? x[31:0] : '0;
		c.y = c.hit ? y[31:0] : '0;
		return c;
	endfunction

	function automatic logic [PT_W-1:0] pt(input int x, input int y);
		return {x[15:0], y[15:0]};
	endfunction

	function automatic pair_t rand_pair();
		pair_t p;
		int cx, cy, w;
		if ($urandom_range(0, 3) == 0) begin
			p.s1a = $urandom; p.s1b = $urandom; p.s2a = $urandom; p.s2b = $urandom;
			p.a1 = AB_W'($urandom); p.b1 = AB_W'($urandom);
			p.a2 = AB_W'($urandom); p.b2 = AB_W'($urandom);
			p.c1 = C_W'({$urandom, $urandom}); p.c2 = C_W'({$urandom, $urandom});
			if ($urandom_range(0, 7) == 0) begin
				p.a2 = p.a1; p.b2 = p.b1;
			end
			return p;
		end
		// Build two lines near a common integer point so that crossings happen.
		cx = int'($urandom_range(0, 2000)) - 1000;
		cy = int'($urandom_range(0, 2000)) - 1000;
		w  = $urandom_range(0, 40);
		p.a1 = AB_W'(int'($urandom_range(0, 400)) - 200);
		p.b1 = AB_W'(int'($urandom_range(0, 400)) - 200);
		p.a2 = AB_W'(int'($urandom_range(0, 400)) - 200);
		p.b2 = AB_W'(int'($urandom_range(0, 400)) - 200);
		p.c1 = C_W'(-(34'(p.a1) * cx + 34'(p.b1) * cy) + int'($urandom_range(0, 6)) - 3);
		p.c2 = C_W'(-(34'(p.a2) * cx + 34'(p.b2) * cy) + int'($urandom_range(0, 6)) - 3);
		p.s1a = pt(cx - $urandom_range(0, w), cy + $urandom_range(0, w));
		p.s1b = pt(cx + $urandom_range(0, w), cy - $urandom_range(0, w));
		p.s2a = pt(cx + $urandom_range(0, w), cy + $urandom_range(0, w));
		p.s2b = pt(cx - $urandom_range(0, w), cy - $urandom_range(0, w));
		return p;
	endfunction

	task automatic send_pair(input pair_t p, input bit typed, input cross_t want);
		item.valid      <= 1'b1;
		item.seg1_start <= p.s1a; item.seg1_end <= p.s1b;
		item.seg2_start <= p.s2a; item.seg2_end <= p.s2b;
		item.line1_a <= p.a1; item.line1_b <= p.b1; item.line1_c <= p.c1;
		item.line2_a <= p.a2; item.line2_b <= p.b2; item.line2_c <= p.c2;
		do @(posedge clk); while (!item.ready);
		crossings_due.push_back(typed ? want : predict_crossing(p));
	endtask

	function automatic pair_t mk(input logic [PT_W-1:0] s1a, s1b, s2a, s2b,
		input int a1, b1, input longint c1, input int a2, b2, input longint c2);
		pair_t p;
		p.s1a = s1a; p.s1b = s1b; p.s2a = s2a; p.s2b = s2b;
		p.a1 = AB_W'(a1); p.b1 = AB_W'(b1); p.c1 = C_W'(c1);
		p.a2 = AB_W'(a2); p.b2 = AB_W'(b2); p.c2 = C_W'(c2);
		return p;
	endfunction

	// Sender: directed table, random bursts, drain pauses after bursts ending between random beats 301 and 330.
	initial begin
		pair_t  rows[$];
		bit     typed[$];
		cross_t wants[$];
		cross_t none;
		int burst;
		none = '{1'b0, '0, '0};
		item.valid <= 1'b0;
		item.seg1_start <= '0; item.seg1_end <= '0; item.seg2_start <= '0; item.seg2_end <= '0;
		item.line1_a <= '0; item.line1_b <= '0; item.line1_c <= '0;
		item.line2_a <= '0; item.line2_b <= '0; item.line2_c <= '0;
		// x=1, y=2 inside both boxes
		rows.push_back(mk(pt(0, 0), pt(4, 4), pt(4, 0), pt(0, 4), 1, 0, -1, 0, 1, -2));
		typed.push_back(1); wants.push_back('{1'b1, 32'h0001_0000, 32'h0002_0000});
		// same point, endpoints swapped; box edge inclusive
		rows.push_back(mk(pt(4, 4), pt(1, 2), pt(1, 2), pt(1, 2), 1, 0, -1, 0, 1, -2));
		typed.push_back(1); wants.push_back('{1'b1, 32'h0001_0000, 32'h0002_0000});
		// parallel lines
		rows.push_back(mk(pt(-5, -5), pt(5, 5), pt(-5, -5), pt(5, 5), 3, 5, 1, 3, 5, 7));
		typed.push_back(1); wants.push_back(none);
		// all-zero, degenerate
		rows.push_back(mk('0, '0, '0, '0, 0, 0, 0, 0, 0, 0));
		typed.push_back(1); wants.push_back(none);
		// outside the box by one
		rows.push_back(mk(pt(0, 0), pt(0, 4), pt(0, 0), pt(4, 4), 1, 0, -1, 0, 1, -2));
		typed.push_back(1); wants.push_back(none);
		// quotient far out of range
		rows.push_back(mk('1, '0, '1, '0, 1, 0, -(64'sd1 << 33), 0, 1, (64'sd1 << 33) - 1));
		typed.push_back(1); wants.push_back(none);
		// extremes of coefficients and points
		rows.push_back(mk('1, 32'h8000_8000, 32'h7FFF_7FFF, '0, 131071, -131072,
			-(64'sd1 << 33), -131072, 131071, (64'sd1 << 33) - 1));
		typed.push_back(0); wants.push_back(none);
		rows.push_back(mk(32'h8000_8000, 32'h7FFF_7FFF, 32'h8000_8000, 32'h7FFF_7FFF,
			-131072, -131072, 1, 131071, -131072, -1));
		typed.push_back(0); wants.push_back(none);
		// fractional point: 3x=1, 7y=-2
		rows.push_back(mk(pt(-1, -1), pt(1, 1), pt(1, -1), pt(-1, 1), 3, 0, -1, 0, 7, 2));
		typed.push_back(0); wants.push_back(none);
		// negative x bound, near edge of Q16.16
		rows.push_back(mk(pt(-32768, -32768), pt(32767, 32767), pt(-32768, 32767),
			pt(32767, -32768), 1, 0, 32768, 0, 1, -32767));
		typed.push_back(0); wants.push_back(none);
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		foreach (rows[i]) send_pair(rows[i], typed[i], wants[i]);
		for (int n = 0; n < N_RANDOM; ) begin
			burst = $urandom_range(1, 30);
			for (int k = 0; k < burst && n < N_RANDOM; k++, n++)
				send_pair(rand_pair(), 1'b0, none);
			if (n > 300 && n <= 330) begin
				item.valid <= 1'b0;
				while (crossings_due.size() != 0) @(posedge clk);
			end else if ($urandom_range(0, 2) != 0) begin
				item.valid <= 1'b0;
				repeat ($urandom_range(1, 6)) @(posedge clk);
			end
		end
		item.valid <= 1'b0;
		feed_done = 1'b1;
	end

	// Receiver: stall pattern, with one long hold-off early on.
	initial begin
		int phase;
		phase = 0;
		result.ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			phase++;
			if (phase >= 100 && phase < 160) begin
				result.ready <= 1'b0;
			end else begin
				result.ready <= (phase % 512 > 256) ? 1'b1 : ($urandom_range(0, 3) != 0);
			end
		end
	end

	// Result checker.
	always @(posedge clk) begin
		cross_t got, want;
		if (arst_n && result.valid && result.ready) begin
			got = '{result.crosses, result.cross_x, result.cross_y};
			if (crossings_due.size() == 0) begin
				report("result beat with nothing expected");
			end else begin
				want = crossings_due.pop_front();
				if (got.hit !== want.hit)
					report($sformatf("crosses %b, want %b", got.hit, want.hit));
				if (got.x !== want.x)
					report($sformatf("cross_x %h, want %h", got.x, want.x));
				if (got.y !== want.y)
					report($sformatf("cross_y %h, want %h", got.y, want.y));
			end
		end
	end

	initial begin
		#3_000_000;
		timed_out = 1'b1;
		$display("FAILURE");
		$finish;
	end

	initial begin
		wait (feed_done);
		while (crossings_due.size() != 0) @(posedge clk);
		repeat (4 * LATENCY) @(posedge clk);
		if (!timed_out) begin
			if (n_err == 0)
				$display("SUCCESS");
			else
				$display("FAILURE");
			$finish;
		end
	end
endmodule

>>> sim.f
src/scp_pkg.sv
src/scp_if.sv
src/scp_front.sv
src/scp_div.sv
src/scp_box.sv
src/segment_crossing_point_unit.sv
verif/scp_tb_if.sv
verif/tb_segment_crossing_point_unit.sv
